// ----- sv/cmc_pkg.sv -----
// Shared types and constants for the coil map combine block.
package cmc_pkg;

    localparam int ACC_W   = 40;
    localparam int VOXIDX_W = 16;
    localparam int CFG_W   = 17;

    typedef enum logic [0:0] {
        CFG_VOXEL_COUNT   = 1'b0,
        CFG_CHANNEL_COUNT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic first;
        logic last_cha;
        logic last_vox;
    } t_flags;

    typedef struct packed {
        logic signed [ACC_W-1:0]  sum_real;
        logic signed [ACC_W-1:0]  sum_imag;
        logic [VOXIDX_W-1:0]      voxel_index;
        logic                     frame_last;
    } t_result;

endpackage

// ----- sv/cmc_ctrl.sv -----
// Configuration registers and voxel/channel position counters.
module cmc_ctrl
    import cmc_pkg::*;
#(
    parameter int MAX_VOXELS   = 65536,
    parameter int MAX_CHANNELS = 64,
    localparam int VW = (MAX_VOXELS > 1) ? $clog2(MAX_VOXELS) : 1,
    localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [0:0]      i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic            i_accept,
    output logic [VW-1:0]   o_idx,
    output t_flags          o_flags
);

    logic [VW-1:0] r_vox_lim;
    logic [CW-1:0] r_cha_lim;
    logic [VW-1:0] r_vox_cnt, n_vox_cnt;
    logic [CW-1:0] r_cha_cnt, n_cha_cnt;
    logic [31:0]   vox_val;
    logic [31:0]   cha_val;
    logic [31:0]   vox_lim32;
    logic [31:0]   cha_lim32;
    logic          last_vox;
    logic          last_cha;

    // clamp the written count to its range and keep count minus one
    always_comb begin
        vox_val = 32'(i_cfg_data);
        cha_val = 32'(i_cfg_data[6:0]);
        if (vox_val == 32'd0) begin
            vox_lim32 = 32'd0;
        end else if (vox_val > 32'(MAX_VOXELS)) begin
            vox_lim32 = 32'(MAX_VOXELS - 1);
        end else begin
            vox_lim32 = vox_val - 32'd1;
        end
        if (cha_val == 32'd0) begin
            cha_lim32 = 32'd0;
        end else if (cha_val > 32'(MAX_CHANNELS)) begin
            cha_lim32 = 32'(MAX_CHANNELS - 1);
        end else begin
            cha_lim32 = cha_val - 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vox_lim <= '0;
            r_cha_lim <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_VOXEL_COUNT:   r_vox_lim <= vox_lim32[VW-1:0];
                CFG_CHANNEL_COUNT: r_cha_lim <= cha_lim32[CW-1:0];
                default: ;
            endcase
        end
    end

    assign last_vox = (r_vox_cnt >= r_vox_lim);
    assign last_cha = (r_cha_cnt >= r_cha_lim);

    always_comb begin
        n_vox_cnt = r_vox_cnt;
        n_cha_cnt = r_cha_cnt;
        if (i_accept) begin
            if (last_vox) begin
                n_vox_cnt = '0;
                n_cha_cnt = last_cha ? '0 : r_cha_cnt + CW'(1);
            end else begin
                n_vox_cnt = r_vox_cnt + VW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vox_cnt <= '0;
            r_cha_cnt <= '0;
        end else begin
            r_vox_cnt <= n_vox_cnt;
            r_cha_cnt <= n_cha_cnt;
        end
    end

    assign o_idx            = r_vox_cnt;
    assign o_flags.first    = (r_cha_cnt == '0);
    assign o_flags.last_cha = last_cha;
    assign o_flags.last_vox = last_vox;

endmodule

// ----- sv/cmc_acc.sv -----
// Complex multiply and read-modify-write accumulation in the voxel store.
module cmc_acc
    import cmc_pkg::*;
#(
    parameter int MAX_VOXELS  = 65536,
    parameter int SAMPLE_BITS = 16,
    localparam int VW = (MAX_VOXELS > 1) ? $clog2(MAX_VOXELS) : 1,
    localparam int PW = 2 * SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [VW-1:0]                 i_idx,
    input  t_flags                        i_flags,
    input  logic signed [SAMPLE_BITS-1:0] i_coil_real,
    input  logic signed [SAMPLE_BITS-1:0] i_coil_imag,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_real,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_imag,
    output logic                          o_res_valid,
    output t_result                       o_res
);

    logic signed [ACC_W-1:0] mem_real [MAX_VOXELS];
    logic signed [ACC_W-1:0] mem_imag [MAX_VOXELS];

    logic                    r_s1_valid;
    logic [VW-1:0]           r_s1_idx;
    t_flags                  r_s1_flags;
    logic signed [PW-1:0]    r_p_rr, r_p_ii, r_p_ir, r_p_ri;
    logic signed [ACC_W-1:0] r_q_real, r_q_imag;
    logic                    r_fwd;
    logic signed [ACC_W-1:0] r_fwd_real, r_fwd_imag;
    logic signed [ACC_W-1:0] base_real, base_imag;
    logic signed [ACC_W-1:0] sum_real, sum_imag;
    logic [31:0]             idx32;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_accept;
        end
    end

    // d * conj(c): products registered before the accumulate add
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_idx   <= i_idx;
            r_s1_flags <= i_flags;
            r_p_rr     <= i_sample_real * i_coil_real;
            r_p_ii     <= i_sample_imag * i_coil_imag;
            r_p_ir     <= i_sample_imag * i_coil_real;
            r_p_ri     <= i_sample_real * i_coil_imag;
            // entry still being written back this edge: forward it
            r_fwd      <= r_s1_valid && (r_s1_idx == i_idx);
            r_fwd_real <= sum_real;
            r_fwd_imag <= sum_imag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_q_real <= mem_real[i_idx];
            r_q_imag <= mem_imag[i_idx];
        end
        if (r_s1_valid) begin
            mem_real[r_s1_idx] <= sum_real;
            mem_imag[r_s1_idx] <= sum_imag;
        end
    end

    always_comb begin
        if (r_s1_flags.first) begin
            base_real = '0;
            base_imag = '0;
        end else if (r_fwd) begin
            base_real = r_fwd_real;
            base_imag = r_fwd_imag;
        end else begin
            base_real = r_q_real;
            base_imag = r_q_imag;
        end
        sum_real = base_real + ACC_W'(r_p_rr) + ACC_W'(r_p_ii);
        sum_imag = base_imag + ACC_W'(r_p_ir) - ACC_W'(r_p_ri);
        idx32    = 32'(r_s1_idx);
    end

    assign o_res_valid       = r_s1_valid && r_s1_flags.last_cha;
    assign o_res.sum_real    = sum_real;
    assign o_res.sum_imag    = sum_imag;
    assign o_res.voxel_index = idx32[VOXIDX_W-1:0];
    assign o_res.frame_last  = r_s1_flags.last_vox;

endmodule

// ----- sv/cmc_out.sv -----
// Output register with a one-entry skid stage.
module cmc_out
    import cmc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_valid,
    output t_result o_res,
    output logic    o_busy
);

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    take;

    always_comb begin
        take         = !r_out_valid || !i_stall;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (take) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = i_res_valid;
                n_skid       = i_res;
            end else begin
                n_out_valid = i_res_valid;
                n_out       = i_res;
            end
        end else if (i_res_valid) begin
            // hold the head, park the new result
            n_skid_valid = 1'b1;
            n_skid       = i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;
    assign o_busy  = r_skid_valid || (r_out_valid && i_res_valid && i_stall);

endmodule

// ----- sv/coil_map_combine_unit.sv -----
// Conjugate-sensitivity-weighted coil combination, top level.
// Items arrive channel-major: for every channel, each voxel of the frame in turn,
// carrying the coil sensitivity c and the data sample d. The block sustains one
// item per clock as long as the result side keeps up. The sum of d*conj(c) per
// voxel lives in a voxel store (two one-port-read, one-port-write memories of
// MAX_VOXELS entries, 40 bits each); an item reads its entry at the transfer
// edge and writes it back in the cycle after, and a forwarding path covers an
// entry that is read while its previous update is still being written, so small
// frames run at full rate too. On the last channel pass the combined sum is
// registered in the output stage before it appears. Store entries are not
// cleared at reset; the first channel pass writes them. Write voxel_count and
// channel_count only while the block is idle.
module coil_map_combine_unit
    import cmc_pkg::*;
#(
    parameter int MAX_VOXELS   = 65536,
    parameter int MAX_CHANNELS = 64,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [0:0]                    i_cfg_index,
    input  logic [CFG_W-1:0]              i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_coil_real,
    input  logic signed [SAMPLE_BITS-1:0] i_coil_imag,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_real,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_imag,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [ACC_W-1:0]       o_sum_real,
    output logic signed [ACC_W-1:0]       o_sum_imag,
    output logic [VOXIDX_W-1:0]           o_voxel_index,
    output logic                          o_frame_last
);

    localparam int VW = (MAX_VOXELS > 1) ? $clog2(MAX_VOXELS) : 1;

    logic          accept;
    logic [VW-1:0] idx;
    t_flags        flags;
    logic          res_valid;
    t_result       res;
    t_result       out_res;
    logic          busy;

    assign o_stall = !i_rst_n || busy;
    assign accept  = i_valid && !o_stall;

    cmc_ctrl #(
        .MAX_VOXELS   (MAX_VOXELS),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .o_idx       (idx),
        .o_flags     (flags)
    );

    cmc_acc #(
        .MAX_VOXELS  (MAX_VOXELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_acc (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_idx         (idx),
        .i_flags       (flags),
        .i_coil_real   (i_coil_real),
        .i_coil_imag   (i_coil_imag),
        .i_sample_real (i_sample_real),
        .i_sample_imag (i_sample_imag),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    cmc_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_res       (out_res),
        .o_busy      (busy)
    );

    assign o_sum_real    = out_res.sum_real;
    assign o_sum_imag    = out_res.sum_imag;
    assign o_voxel_index = out_res.voxel_index;
    assign o_frame_last  = out_res.frame_last;

endmodule

// ----- sv/cmc_check.sv -----
// Port-level checks for the coil map combine block, bound to the top level.
module cmc_check
    import cmc_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_valid,
    input logic                    o_stall,
    input logic                    o_valid,
    input logic                    i_stall,
    input logic signed [ACC_W-1:0] o_sum_real,
    input logic signed [ACC_W-1:0] o_sum_imag,
    input logic [VOXIDX_W-1:0]     o_voxel_index,
    input logic                    o_frame_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_sum_real) && $stable(o_sum_imag)
            && $stable(o_voxel_index) && $stable(o_frame_last))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present after reset");

    a_rise_needs_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall, 2))
        else $error("result without a matching input transfer");

endmodule

bind coil_map_combine_unit cmc_check u_cmc_check (.*);
